// ===== sv/srgblab_pkg.sv =====
// Types, widths and constants shared by the sRGB to CIELAB pipeline.
// Holds the sRGB linearization table, built at elaboration, and the matrix coefficients.
// No dependencies.
package srgblab_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [14:0]        lightness;
    logic signed [15:0] green_red;
    logic signed [15:0] blue_yellow;
  } lab_t;

  localparam int QB      = 30;
  localparam int LIN_W   = 31;
  localparam int COEF_W  = 30;
  localparam int PROD_W  = 61;
  localparam int SUM_W   = 63;
  localparam int T_W     = 31;
  localparam int ROOT_W  = 31;
  localparam int CBRT_DEPTH = 2 * ROOT_W;

  localparam logic [SUM_W-1:0] HALF_Q = SUM_W'(1) << (QB - 1);

  // Linear segment of f(): (7787 t + 500) / 1000 + 16/116
  localparam int LT_W = 24;
  localparam int LX_W = 37;
  localparam int LY_W = 34;
  localparam int LP_W = 64;
  localparam int LQ_W = 28;
  localparam int LIN_SHIFT = 36;
  localparam logic [12:0] F_SLOPE = 13'd7787;
  localparam logic [8:0]  F_ROUND = 9'd500;
  localparam logic [6:0]  LIN_DIV = 7'd125;
  localparam logic [LP_W-1:0] LIN_M = (64'd1 << LIN_SHIFT) / 64'd125;
  localparam logic [T_W-1:0] F_OFF = T_W'(((64'd4 << QB) + 64'd29 / 2) / 64'd29);
  localparam logic [T_W-1:0] F_THRESH = T_W'((64'd8856 << QB) / 64'd1000000);

  localparam logic [COEF_W-1:0] MAT_Q [9] = '{
    COEF_W'(((64'd41240 << QB) + 64'd95047 / 2) / 64'd95047),
    COEF_W'(((64'd35760 << QB) + 64'd95047 / 2) / 64'd95047),
    COEF_W'(((64'd18050 << QB) + 64'd95047 / 2) / 64'd95047),
    COEF_W'(((64'd2126 << QB) + 64'd10000 / 2) / 64'd10000),
    COEF_W'(((64'd7152 << QB) + 64'd10000 / 2) / 64'd10000),
    COEF_W'(((64'd722 << QB) + 64'd10000 / 2) / 64'd10000),
    COEF_W'(((64'd1930 << QB) + 64'd108883 / 2) / 64'd108883),
    COEF_W'(((64'd11920 << QB) + 64'd108883 / 2) / 64'd108883),
    COEF_W'(((64'd95050 << QB) + 64'd108883 / 2) / 64'd108883)
  };

  typedef logic [LIN_W-1:0] lin_table_t [256];

  function automatic logic [63:0] mul_q(logic [63:0] a, logic [63:0] b);
    return (a * b + (64'd1 << (QB - 1))) >> QB;
  endfunction

  function automatic logic [63:0] pow5_q(logic [63:0] y);
    logic [63:0] p;
    p = y;
    for (int i = 1; i < 5; i++) begin
      p = mul_q(p, y);
    end
    return p;
  endfunction

  function automatic lin_table_t build_lin_table();
    lin_table_t tab;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] r;
    logic [63:0] mid;
    for (int c = 0; c < 256; c++) begin
      if (c <= 10) begin
        tab[c] = LIN_W'(((64'(c) * 64'd10 << QB) + 64'd16473) / 64'd32946);
      end else begin
        t = (((64'd1000 * 64'(c) + 64'd14025) << QB) + 64'd134512) / 64'd269025;
        t2 = mul_q(t, t);
        r = 64'd0;
        for (int i = QB; i >= 0; i--) begin
          mid = r | (64'd1 << i);
          if (pow5_q(mid) <= t2) begin
            r = mid;
          end
        end
        tab[c] = LIN_W'(mul_q(t2, r));
      end
    end
    return tab;
  endfunction

  localparam lin_table_t LIN_TABLE = build_lin_table();

endpackage

// ===== sv/srgb_to_cielab.sv =====
// sRGB to CIELAB (D65) converter, one pixel per clock while the output is not stalled.
// Depends on srgblab_pkg and srgblab_cbrt.
//
// Usage:
//   Input channel pixel / pixel_valid / pixel_stall carries 8-bit red, green, blue.
//   Output channel lab / lab_valid / lab_stall carries L*, a*, b* in fixed point
//   with FRAC_BITS fraction bits (L* unsigned 15 bits, a* and b* signed 16 bits).
//   Throughput: one item per clock while not stalled, no gaps between back-to-back items.
//   Latency: 68 register stages. The cube root units set most of it (31 result
//   bits, two register stages per bit), plus six table, matrix and output stages.
//   Stall: while lab_valid and lab_stall are both high, the whole pipeline holds,
//   empty slots included, and pixel_stall is high.
//   The output register keeps its item stable until it is taken.
//   Reset: rst (synchronous) clears all valid bits; the pipeline is empty after it.
module srgb_to_cielab #(
  parameter int FRAC_BITS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                pixel_valid,
  output logic                pixel_stall,
  input  srgblab_pkg::pixel_t pixel,
  output logic                lab_valid,
  input  logic                lab_stall,
  output srgblab_pkg::lab_t   lab
);

  localparam int T_W        = srgblab_pkg::T_W;
  localparam int QB         = srgblab_pkg::QB;
  localparam int LAB_W      = 42;
  localparam int SHIFT      = QB - FRAC_BITS;
  localparam int CBRT_DEPTH = srgblab_pkg::CBRT_DEPTH;
  localparam int SIDE_DEPTH = CBRT_DEPTH - 2;
  localparam int NUM_STAGES = CBRT_DEPTH + 6;
  localparam int ST_T       = 2;
  localparam int L_MAX_INT  = ((100 << FRAC_BITS) < 32767) ? (100 << FRAC_BITS) : 32767;

  localparam logic [LAB_W-1:0]        ROUND_HALF = LAB_W'(1) << (SHIFT - 1);
  localparam logic signed [LAB_W-1:0] L_MAX      = LAB_W'(L_MAX_INT);
  localparam logic [14:0]             L_MAX_OUT  = 15'(L_MAX_INT);
  localparam logic signed [LAB_W-1:0] C_MAX      = LAB_W'(32767);
  localparam logic signed [LAB_W-1:0] C_MIN      = -LAB_W'(32768);
  localparam logic signed [LAB_W-1:0] K116       = LAB_W'(116);
  localparam logic signed [LAB_W-1:0] K500       = LAB_W'(500);
  localparam logic signed [LAB_W-1:0] K200       = LAB_W'(200);
  localparam logic signed [LAB_W-1:0] L_OFS      = LAB_W'(16) << QB;

  typedef struct packed {
    logic [2:0][T_W-1:0] lin_f;
    logic [2:0]          sel;
  } side_t;

  logic                              advance;
  logic [NUM_STAGES-1:0]             vld;
  logic [srgblab_pkg::LIN_W-1:0]     lin   [3];
  logic [srgblab_pkg::PROD_W-1:0]    prod  [9];
  logic [srgblab_pkg::SUM_W-1:0]     xyz_sum [3];
  logic [T_W-1:0]                    tval  [3];
  logic [srgblab_pkg::LX_W-1:0]      lx    [3];
  logic [2:0]                        lsel1;
  logic [srgblab_pkg::LY_W-1:0]      ly    [3];
  logic [srgblab_pkg::LP_W-1:0]      lp    [3];
  logic [2:0]                        lsel2;
  logic [srgblab_pkg::LQ_W-1:0]      lq0   [3];
  logic [srgblab_pkg::LY_W-1:0]      lin_rem [3];
  logic [srgblab_pkg::LQ_W-1:0]      lq    [3];
  side_t                             side_dly [SIDE_DEPTH];
  logic [srgblab_pkg::ROOT_W-1:0]    root  [3];
  logic [T_W-1:0]                    fval  [3];
  logic signed [LAB_W-1:0]           fx, fy, fz;
  logic signed [LAB_W-1:0]           lab_l, lab_a, lab_b;
  logic signed [LAB_W-1:0]           lr, ar, br;

  function automatic logic signed [LAB_W-1:0] round_q(logic signed [LAB_W-1:0] v);
    logic [LAB_W-1:0] mag;
    logic [LAB_W-1:0] rm;
    mag = v[LAB_W-1] ? LAB_W'(-v) : LAB_W'(v);
    rm  = (mag + ROUND_HALF) >> SHIFT;
    return v[LAB_W-1] ? -$signed(rm) : $signed(rm);
  endfunction

  assign lab_valid   = vld[NUM_STAGES-1];
  assign advance     = !lab_valid || !lab_stall;
  assign pixel_stall = !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[NUM_STAGES-2:0], pixel_valid};
    end
  end

  // linearize, matrix, normalized XYZ
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      xyz_sum[r] = srgblab_pkg::SUM_W'(prod[3*r]) + srgblab_pkg::SUM_W'(prod[3*r+1])
                 + srgblab_pkg::SUM_W'(prod[3*r+2]) + srgblab_pkg::HALF_Q;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lin[0] <= srgblab_pkg::LIN_TABLE[pixel.red];
      lin[1] <= srgblab_pkg::LIN_TABLE[pixel.green];
      lin[2] <= srgblab_pkg::LIN_TABLE[pixel.blue];
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod[3*r+k] <= srgblab_pkg::PROD_W'(srgblab_pkg::MAT_Q[3*r+k])
                       * srgblab_pkg::PROD_W'(lin[k]);
        end
        tval[r] <= T_W'(xyz_sum[r] >> QB);
      end
    end
  end

  // linear segment of f(), divide by 1000 as shift then reciprocal multiply
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      lq0[k]     = srgblab_pkg::LQ_W'(lp[k] >> srgblab_pkg::LIN_SHIFT);
      lin_rem[k] = ly[k] - srgblab_pkg::LY_W'(lq0[k]) * srgblab_pkg::LY_W'(srgblab_pkg::LIN_DIV);
      lq[k]      = (lin_rem[k] >= srgblab_pkg::LY_W'(srgblab_pkg::LIN_DIV))
                 ? lq0[k] + srgblab_pkg::LQ_W'(1) : lq0[k];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < 3; k++) begin
        lx[k]    <= srgblab_pkg::LX_W'(tval[k][srgblab_pkg::LT_W-1:0])
                  * srgblab_pkg::LX_W'(srgblab_pkg::F_SLOPE)
                  + srgblab_pkg::LX_W'(srgblab_pkg::F_ROUND);
        lsel1[k] <= tval[k] > srgblab_pkg::F_THRESH;
        ly[k]    <= srgblab_pkg::LY_W'(lx[k] >> 3);
        lp[k]    <= srgblab_pkg::LP_W'(srgblab_pkg::LY_W'(lx[k] >> 3)) * srgblab_pkg::LIN_M;
        lsel2[k] <= lsel1[k];
        side_dly[0].lin_f[k] <= T_W'(lq[k]) + srgblab_pkg::F_OFF;
      end
      side_dly[0].sel <= lsel2;
      for (int i = 1; i < SIDE_DEPTH; i++) begin
        side_dly[i] <= side_dly[i-1];
      end
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_root
    srgblab_cbrt u_cbrt (
      .clk     (clk),
      .advance (advance),
      .v       (tval[k]),
      .root    (root[k])
    );
  end

  // select f(), form L a b, round and saturate
  assign fx = LAB_W'(fval[0]);
  assign fy = LAB_W'(fval[1]);
  assign fz = LAB_W'(fval[2]);
  assign lr = round_q(lab_l);
  assign ar = round_q(lab_a);
  assign br = round_q(lab_b);

  always_ff @(posedge clk) begin
    if (advance) begin
      for (int k = 0; k < 3; k++) begin
        fval[k] <= side_dly[SIDE_DEPTH-1].sel[k] ? T_W'(root[k])
                                                 : side_dly[SIDE_DEPTH-1].lin_f[k];
      end
      lab_l <= K116 * fy - L_OFS;
      lab_a <= K500 * (fx - fy);
      lab_b <= K200 * (fy - fz);
      if (lr < 0) begin
        lab.lightness <= '0;
      end else if (lr > L_MAX) begin
        lab.lightness <= L_MAX_OUT;
      end else begin
        lab.lightness <= lr[14:0];
      end
      if (ar < C_MIN) begin
        lab.green_red <= 16'sh8000;
      end else if (ar > C_MAX) begin
        lab.green_red <= 16'sh7fff;
      end else begin
        lab.green_red <= ar[15:0];
      end
      if (br < C_MIN) begin
        lab.blue_yellow <= 16'sh8000;
      end else if (br > C_MAX) begin
        lab.blue_yellow <= 16'sh7fff;
      end else begin
        lab.blue_yellow <= br[15:0];
      end
    end
  end

`ifndef SYNTHESIS
  a_reset_empty: assert property (@(posedge clk) rst |=> vld == '0)
    else $error("pipeline not empty after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !advance |=> vld == $past(vld))
    else $error("valid bits moved while pipeline held");

  a_div_correction: assert property (@(posedge clk) disable iff (rst)
    vld[ST_T+2] |-> (lin_rem[0] < 34'd250) && (lin_rem[1] < 34'd250) && (lin_rem[2] < 34'd250))
    else $error("reciprocal divide off by more than one");

  a_lightness_range: assert property (@(posedge clk) disable iff (rst)
    lab_valid |-> lab.lightness <= L_MAX_OUT)
    else $error("lightness above saturation limit");
`endif

endmodule

// ===== sv/srgblab_cbrt.sv =====
// Pipelined cube root in Q30: one result bit per two register stages.
// Gives the largest root whose rounded Q30 cube does not exceed the operand.
// Depends on srgblab_pkg.
module srgblab_cbrt (
  input  logic                           clk,
  input  logic                           advance,
  input  logic [srgblab_pkg::T_W-1:0]    v,
  output logic [srgblab_pkg::ROOT_W-1:0] root
);

  localparam int RW   = srgblab_pkg::ROOT_W;
  localparam int QB   = srgblab_pkg::QB;
  localparam int SQ_W = 2 * RW;
  localparam int P2_W = RW + 1;
  localparam int CU_W = P2_W + RW;
  localparam int CQ_W = CU_W - QB;

  logic [RW-1:0]   mid_r [RW];
  logic [P2_W-1:0] p2_r  [RW];
  logic [RW-1:0]   vm_r  [RW];
  logic [RW-1:0]   x_st  [RW];
  logic [RW-1:0]   v_st  [RW-1];

  for (genvar g = 0; g < RW; g++) begin : g_bit
    localparam int BIT = RW - 1 - g;
    logic [RW-1:0]   x_prev;
    logic [RW-1:0]   v_prev;
    logic [RW-1:0]   mid;
    logic [SQ_W-1:0] sq;
    logic [CU_W-1:0] cube;
    logic [CQ_W-1:0] cube_q;

    if (g == 0) begin : g_first
      assign x_prev = '0;
      assign v_prev = v;
    end else begin : g_next
      assign x_prev = x_st[g-1];
      assign v_prev = v_st[g-1];
    end

    assign mid    = x_prev | (RW'(1) << BIT);
    assign sq     = SQ_W'(mid) * SQ_W'(mid);
    assign cube   = CU_W'(p2_r[g]) * CU_W'(mid_r[g]);
    assign cube_q = CQ_W'((cube + CU_W'(1 << (QB - 1))) >> QB);

    always_ff @(posedge clk) begin
      if (advance) begin
        mid_r[g] <= mid;
        p2_r[g]  <= P2_W'((sq + SQ_W'(1 << (QB - 1))) >> QB);
        vm_r[g]  <= v_prev;
        x_st[g]  <= (cube_q <= CQ_W'(vm_r[g])) ? mid_r[g] : (mid_r[g] & ~(RW'(1) << BIT));
      end
    end

    if (g < RW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (advance) begin
          v_st[g] <= vm_r[g];
        end
      end
    end
  end

  assign root = x_st[RW-1];

endmodule

// ===== dv/tb_top.sv =====
// Testbench for srgb_to_cielab: drives sRGB pixels, predicts L*, a*, b* with its own
// fixed-point model and checks every result in order under random idling and back-pressure.
// Depends on srgblab_pkg (pixel_t, lab_t) and the srgb_to_cielab RTL.
`timescale 1ns / 1ps

module tb_top;

  localparam int FRAC        = 8;
  localparam int QB          = 30;
  localparam int DRAIN_WAIT  = 80;
  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_LEN    = 300;
  localparam int MAX_REPORTS = 10;

  localparam logic [63:0] QONE = 64'd1 << QB;
  localparam logic [63:0] QHALF = 64'd1 << (QB - 1);

  localparam logic [63:0] XYZ_NUM [9] = '{
    64'd41240, 64'd35760, 64'd18050,
    64'd2126,  64'd7152,  64'd722,
    64'd1930,  64'd11920, 64'd95050
  };
  localparam logic [63:0] WHITE_DEN [3] = '{64'd95047, 64'd10000, 64'd108883};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pixel_valid = 1'b0;
  logic pixel_stall;
  srgblab_pkg::pixel_t pixel = '0;
  logic lab_valid;
  logic lab_stall = 1'b0;
  srgblab_pkg::lab_t lab;

  srgblab_pkg::lab_t lab_due [$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  srgb_to_cielab #(.FRAC_BITS(FRAC)) dut (
    .clk        (clk),
    .rst        (rst),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel      (pixel),
    .lab_valid  (lab_valid),
    .lab_stall  (lab_stall),
    .lab        (lab)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
    return (a * b + QHALF) >> QB;
  endfunction

  function automatic logic [63:0] qpow(logic [63:0] y, int n);
    logic [63:0] p;
    p = y;
    for (int i = 1; i < n; i++) p = qmul(p, y);
    return p;
  endfunction

  function automatic logic [63:0] qroot(logic [63:0] v, int n, logic [63:0] hi);
    logic [63:0] lo;
    logic [63:0] mid;
    lo = 64'd0;
    while (lo < hi) begin
      mid = lo + (hi - lo + 64'd1) / 64'd2;
      if (qpow(mid, n) <= v) lo = mid;
      else hi = mid - 64'd1;
    end
    return lo;
  endfunction

  function automatic logic [63:0] qratio(logic [63:0] num, logic [63:0] den);
    return ((num << QB) + den / 64'd2) / den;
  endfunction

  function automatic logic [63:0] gamma_expand(logic [7:0] c);
    logic [63:0] t;
    logic [63:0] t2;
    if (c <= 8'd10) return (((64'(c) * 64'd10) << QB) + 64'd16473) / 64'd32946;
    t = (((64'd1000 * 64'(c) + 64'd14025) << QB) + 64'd134512) / 64'd269025;
    t2 = qmul(t, t);
    return qmul(t2, qroot(t2, 5, QONE));
  endfunction

  function automatic logic [63:0] cie_f(logic [63:0] t);
    if (t * 64'd1000000 > (64'd8856 << QB)) return qroot(t, 3, 2 * QONE);
    return (64'd7787 * t + 64'd500) / 64'd1000 + qratio(64'd4, 64'd29);
  endfunction

  function automatic longint round_frac(longint v);
    longint half;
    half = longint'(1) <<< (QB - FRAC - 1);
    if (v >= 0) return (v + half) >>> (QB - FRAC);
    return -((-v + half) >>> (QB - FRAC));
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic srgblab_pkg::lab_t predict_lab(srgblab_pkg::pixel_t p);
    logic [63:0] lin [3];
    logic [63:0] fv [3];
    logic [63:0] acc;
    longint l_q;
    longint a_q;
    longint b_q;
    srgblab_pkg::lab_t r;
    lin[0] = gamma_expand(p.red);
    lin[1] = gamma_expand(p.green);
    lin[2] = gamma_expand(p.blue);
    for (int row = 0; row < 3; row++) begin
      acc = 64'd0;
      for (int k = 0; k < 3; k++) begin
        acc += qratio(XYZ_NUM[row * 3 + k], WHITE_DEN[row]) * lin[k];
      end
      fv[row] = cie_f((acc + QHALF) >> QB);
    end
    l_q = 116 * longint'(fv[1]) - (longint'(16) <<< QB);
    a_q = 500 * (longint'(fv[0]) - longint'(fv[1]));
    b_q = 200 * (longint'(fv[1]) - longint'(fv[2]));
    l_q = clamp(clamp(round_frac(l_q), 0, longint'(100) <<< FRAC), 0, 32767);
    a_q = clamp(round_frac(a_q), -32768, 32767);
    b_q = clamp(round_frac(b_q), -32768, 32767);
    r.lightness   = 15'(l_q);
    r.green_red   = 16'(a_q);
    r.blue_yellow = 16'(b_q);
    return r;
  endfunction

  function automatic srgblab_pkg::pixel_t random_pixel();
    srgblab_pkg::pixel_t p;
    int mode;
    logic [7:0] g;
    mode = $urandom_range(99);
    p = srgblab_pkg::pixel_t'($urandom);
    if (mode < 15) begin
      g = 8'($urandom);
      p = '{red: g, green: g, blue: g};
    end else if (mode < 30) begin
      p.red   = 8'($urandom_range(30));
      p.green = 8'($urandom_range(30));
      p.blue  = 8'($urandom_range(30));
    end else if (mode < 40) begin
      p.red   = $urandom_range(1) ? 8'hFF : 8'h00;
      p.green = $urandom_range(1) ? 8'hFF : 8'h00;
      p.blue  = $urandom_range(1) ? 8'hFF : 8'h00;
    end
    return p;
  endfunction

  task automatic send_pixel(srgblab_pkg::pixel_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= p;
    do @(posedge clk); while (pixel_stall);
  endtask

  task automatic test_directed();
    srgblab_pkg::pixel_t pix [$];
    pix = '{
      '{8'h00, 8'h00, 8'h00}, '{8'hFF, 8'hFF, 8'hFF},
      '{8'hFF, 8'h00, 8'h00}, '{8'h00, 8'hFF, 8'h00}, '{8'h00, 8'h00, 8'hFF},
      '{8'hFF, 8'hFF, 8'h00}, '{8'h00, 8'hFF, 8'hFF}, '{8'hFF, 8'h00, 8'hFF},
      '{8'd1, 8'd1, 8'd1}, '{8'd10, 8'd10, 8'd10}, '{8'd11, 8'd11, 8'd11},
      '{8'd1, 8'd0, 8'd0}, '{8'd0, 8'd1, 8'd0}, '{8'd0, 8'd0, 8'd1},
      '{8'd24, 8'd24, 8'd24}, '{8'd25, 8'd25, 8'd25}, '{8'd128, 8'd128, 8'd128},
      '{8'hAA, 8'h55, 8'hAA}, '{8'h55, 8'hAA, 8'h55}, '{8'd20, 8'd0, 8'd255},
      '{8'd255, 8'd10, 8'd11}
    };
    foreach (pix[i]) send_pixel(pix[i]);
  endtask

  task automatic test_random(int count, int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (count) send_pixel(random_pixel());
  endtask

  task automatic test_backpressure(int count);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    repeat (count) send_pixel(random_pixel());
  endtask

  // Receiver: random stall, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_LEN;
    end
    if (hold_left > 0) begin
      lab_stall <= 1'b1;
      hold_left--;
    end else begin
      lab_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && pixel_valid && !pixel_stall) lab_due.push_back(predict_lab(pixel));
  end

  always @(posedge clk) begin
    srgblab_pkg::lab_t want;
    if (!rst && lab_valid && !lab_stall) begin
      if (lab_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected item: L=%0d a=%0d b=%0d", lab.lightness, lab.green_red,
                   lab.blue_yellow);
      end else begin
        want = lab_due.pop_front();
        if (lab.lightness !== want.lightness || lab.green_red !== want.green_red ||
            lab.blue_yellow !== want.blue_yellow) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch: expected L=%0d a=%0d b=%0d, actual L=%0d a=%0d b=%0d",
                     want.lightness, want.green_red, want.blue_yellow,
                     lab.lightness, lab.green_red, lab.blue_yellow);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((pixel_valid && !pixel_stall) || (lab_valid && !lab_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 13;
    recv_idle_pct = 87;
    test_directed();
    test_random(140, 13, 87);
    test_random(140, 87, 13);
    test_random(140, 0, 0);
    test_backpressure(120);
    pixel_valid <= 1'b0;
    while (lab_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && lab_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/srgblab_pkg.sv
sv/srgblab_cbrt.sv
sv/srgb_to_cielab.sv
dv/tb_top.sv
